@@ hw/rtl/wamf_pkg.sv @@
// Shared types and constants of the window average and median filter.
`default_nettype none

package wamf_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned STEP_W = $clog2(DATA_W);
  localparam int unsigned IN_TDATA_W = 32;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned HELD_W = 5;

  typedef struct packed {
    logic load;
    logic step;
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/wamf_div.sv @@
// Bit-serial restoring divider for the window mean, one quotient bit per cycle while the step control is set.
`default_nettype none

module wamf_div #(
  parameter int unsigned CNT_W = 5
) (
  input  wire logic                                   clk_i,
  input  wire wamf_pkg::ctl_t                         ctl_i,
  input  wire logic [wamf_pkg::DATA_W+CNT_W-1:0]      dividend_i,
  input  wire logic [CNT_W-1:0]                       divisor_i,
  output logic      [wamf_pkg::DATA_W-1:0]            quot_o
);

  logic [CNT_W-1:0]            rem_q, rem_d;
  logic [CNT_W-1:0]            dsr_q, dsr_d;
  logic [wamf_pkg::DATA_W-1:0] quo_q, quo_d;
  logic [CNT_W:0]              trial;
  logic [CNT_W:0]              diff;
  logic                        qbit;

  always_comb begin
    trial = {rem_q, quo_q[wamf_pkg::DATA_W-1]};
    diff  = trial - {1'b0, dsr_q};
    qbit  = (trial >= {1'b0, dsr_q});
    rem_d = rem_q;
    dsr_d = dsr_q;
    quo_d = quo_q;
    if (ctl_i.load) begin
      rem_d = dividend_i[wamf_pkg::DATA_W+CNT_W-1:wamf_pkg::DATA_W];
      quo_d = dividend_i[wamf_pkg::DATA_W-1:0];
      dsr_d = divisor_i;
    end else if (ctl_i.step) begin
      rem_d = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d = {quo_q[wamf_pkg::DATA_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign quot_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/wamf_rank.sv @@
// Bit-serial rank selection that finds the median, most significant bit first.
`default_nettype none

module wamf_rank #(
  parameter int unsigned LANES = 16,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic                            clk_i,
  input  wire wamf_pkg::ctl_t                  ctl_i,
  input  wire logic [LANES-1:0]                valid_i,
  input  wire logic [CNT_W-1:0]                rank_i,
  input  wire logic [LANES-1:0]                key_bit_i,
  output logic      [wamf_pkg::DATA_W-1:0]     result_o
);

  logic [LANES-1:0]            cand_q, cand_d;
  logic [CNT_W-1:0]            rank_q, rank_d;
  logic [wamf_pkg::DATA_W-1:0] res_q, res_d;
  logic [CNT_W-1:0]            zeros;
  logic                        rbit;

  always_comb begin
    zeros = '0;
    for (int unsigned i = 0; i < LANES; i++) begin
      zeros = zeros + CNT_W'(cand_q[i] & ~key_bit_i[i]);
    end
    rbit   = (rank_q >= zeros);
    cand_d = cand_q;
    rank_d = rank_q;
    res_d  = res_q;
    if (ctl_i.load) begin
      cand_d = valid_i;
      rank_d = rank_i;
    end else if (ctl_i.step) begin
      res_d = {res_q[wamf_pkg::DATA_W-2:0], rbit};
      if (rbit) begin
        cand_d = cand_q & key_bit_i;
        rank_d = rank_q - zeros;
      end else begin
        cand_d = cand_q & ~key_bit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    rank_q <= rank_d;
    res_q  <= res_d;
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/window_average_median_filter_core.sv @@
// Top level of the window average and median filter.
// Each sample transfer on the slave channel pushes a signed Q16.16 sample into a
// shift line that keeps the last WINDOW samples, and one result transfer follows
// on the master channel with the mean, the median and the number of samples used.
// Before WINDOW samples have arrived, only the samples received so far count.
// A running sum is updated as the sample enters. A bit-serial divider then forms
// the mean while a bit-serial rank search walks the held samples from the most
// significant bit down to find the median; both take one bit per cycle.
// An item goes from its transfer through a load of the serial units, the bit steps
// and the registering of the result. The next sample is taken in the cycle after
// that; no new sample is accepted while an item is still in progress.
// The next sample may be taken while a result still waits in the output register;
// if the receiver stalls, the following result holds until that register frees.
// Reset empties the window, clears the sum and drops any pending result.
`default_nettype none

module window_average_median_filter_core #(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // Fields from bit 0: sample[31:0].
  input  wire logic [wamf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // Fields from bit 0: mean_value[31:0], median_value[63:32], samples_held[68:64].
  output logic      [wamf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = wamf_pkg::DATA_W + $clog2(WINDOW) + 1;
  localparam int unsigned DW    = wamf_pkg::DATA_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  logic [wamf_pkg::STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [DW-1:0]             lane_q [WINDOW];
  logic                      neg_q;
  logic                      out_valid_q, out_valid_d;
  logic [DW-1:0]             mean_q, median_q;
  logic [CNT_W-1:0]          held_q;

  logic                      in_xfer;
  logic                      full;
  logic signed [SUM_W-1:0]   drop_val;
  logic [SUM_W-1:0]          mag;
  logic [WINDOW-1:0]         valid_mask;
  logic [WINDOW-1:0]         key_bits;
  logic                      first_step;
  logic                      out_load;
  wamf_pkg::ctl_t            ctl;
  logic [DW-1:0]             quot;
  logic [DW-1:0]             rank_res;
  logic [CNT_W+wamf_pkg::HELD_W-1:0] held_ext;

  assign s_axis_tready = state_q == ST_IDLE;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign full          = cnt_q == CNT_W'(WINDOW);
  assign drop_val      = full ? SUM_W'($signed(lane_q[WINDOW-1])) : '0;
  assign mag           = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign first_step    = step_q == '0;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign ctl.load      = state_q == ST_LOAD;
  assign ctl.step      = state_q == ST_RUN;

  for (genvar i = 0; i < WINDOW; i++) begin : g_lane_taps
    assign valid_mask[i] = cnt_q > CNT_W'(i);
    assign key_bits[i]   = lane_q[i][DW-1] ^ first_step;
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          sum_d = sum_q + SUM_W'($signed(s_axis_tdata[DW-1:0])) - drop_val;
          if (!full) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        step_d  = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        step_d = step_q + wamf_pkg::STEP_W'(1);
        if (step_q == wamf_pkg::STEP_W'(DW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      lane_q[0] <= s_axis_tdata[DW-1:0];
      for (int unsigned i = 1; i < WINDOW; i++) begin
        lane_q[i] <= lane_q[i-1];
      end
    end else if (ctl.step) begin
      for (int unsigned i = 0; i < WINDOW; i++) begin
        lane_q[i] <= {lane_q[i][DW-2:0], lane_q[i][DW-1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      neg_q <= sum_q[SUM_W-1];
    end
    if (out_load) begin
      mean_q   <= neg_q ? DW'(-quot) : quot;
      median_q <= rank_res ^ {1'b1, {(DW-1){1'b0}}};
      held_q   <= cnt_q;
    end
  end

  wamf_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .dividend_i (mag[DW+CNT_W-1:0]),
    .divisor_i  (cnt_q),
    .quot_o     (quot)
  );

  wamf_rank #(
    .LANES (WINDOW),
    .CNT_W (CNT_W)
  ) u_rank (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .valid_i   (valid_mask),
    .rank_i    (cnt_q >> 1),
    .key_bit_i (key_bits),
    .result_o  (rank_res)
  );

  assign held_ext      = {{wamf_pkg::HELD_W{1'b0}}, held_q};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, held_ext[wamf_pkg::HELD_W-1:0], median_q, mean_q};

endmodule

`default_nettype wire
